// ===== hdl/vna_pkg.sv =====
package vna_pkg;

    localparam int unsigned VERTEX_DEPTH_DEF = 4096;
    localparam int unsigned INDEX_W          = 12;
    localparam int unsigned COORD_W          = 16;
    localparam int unsigned EDGE_W           = COORD_W + 1;
    localparam int unsigned PROD_W           = 2 * EDGE_W;
    localparam int unsigned CROSS_W          = PROD_W + 1;
    localparam int unsigned ACC_W            = 48;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_TRIANGLE = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                op;
        logic [INDEX_W-1:0]        index_a;
        logic [INDEX_W-1:0]        index_b;
        logic [INDEX_W-1:0]        index_c;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } cmd_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] normal_x;
        logic signed [ACC_W-1:0] normal_y;
        logic signed [ACC_W-1:0] normal_z;
    } rsp_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } normal_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] x;
        logic signed [CROSS_W-1:0] y;
        logic signed [CROSS_W-1:0] z;
    } cross_t;

    typedef struct packed {
        logic edge_en;
        logic prod_en;
        logic cross_en;
    } cross_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VB,
        ST_VC,
        ST_EDGE,
        ST_MUL,
        ST_CROSS,
        ST_ACC_A,
        ST_ACC_B,
        ST_ACC_C,
        ST_READ
    } state_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]   acc,
        input logic signed [CROSS_W-1:0] d
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(d);
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ===== hdl/vna_chan_if.sv =====
interface vna_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/vna_ram.sv =====
module vna_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/vna_cross.sv =====
module vna_cross import vna_pkg::*; (
    input  logic        clk,
    input  cross_ctrl_t ctrl,
    input  vertex_t     va,
    input  vertex_t     vb,
    input  vertex_t     vc,
    output cross_t      n
);

    logic signed [EDGE_W-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [EDGE_W-1:0] e2x_reg, e2y_reg, e2z_reg;
    logic signed [PROD_W-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    cross_t                   n_reg;

    // Edges, six products and the three differences each sit behind a register.
    always_ff @(posedge clk)
    begin
        if (ctrl.edge_en)
        begin
            e1x_reg <= EDGE_W'(vb.x) - EDGE_W'(va.x);
            e1y_reg <= EDGE_W'(vb.y) - EDGE_W'(va.y);
            e1z_reg <= EDGE_W'(vb.z) - EDGE_W'(va.z);
            e2x_reg <= EDGE_W'(vc.x) - EDGE_W'(vb.x);
            e2y_reg <= EDGE_W'(vc.y) - EDGE_W'(vb.y);
            e2z_reg <= EDGE_W'(vc.z) - EDGE_W'(vb.z);
        end
        if (ctrl.prod_en)
        begin
            p_yz_reg <= e1y_reg * e2z_reg;
            p_zy_reg <= e1z_reg * e2y_reg;
            p_zx_reg <= e1z_reg * e2x_reg;
            p_xz_reg <= e1x_reg * e2z_reg;
            p_xy_reg <= e1x_reg * e2y_reg;
            p_yx_reg <= e1y_reg * e2x_reg;
        end
        if (ctrl.cross_en)
        begin
            n_reg.x <= CROSS_W'(p_yz_reg) - CROSS_W'(p_zy_reg);
            n_reg.y <= CROSS_W'(p_zx_reg) - CROSS_W'(p_xz_reg);
            n_reg.z <= CROSS_W'(p_xy_reg) - CROSS_W'(p_yx_reg);
        end
    end

    assign n = n_reg;

endmodule

// ===== hdl/vertex_normal_accumulator.sv =====
// Vertex write: one word a cycle while idle. Normal read: the result word is registered in
// ST_READ once the output register is free; the next word is taken when ST_READ ends, later
// while an older result word waits. Triangle: no word is taken until the sequence of three
// vertex reads through one read port, the edge/product/cross pipeline and three read-modify-
// writes of the single normal memory has ended. Reset: the normal memory is cleared one entry
// a cycle, all VERTEX_DEPTH entries, with no word accepted meanwhile; the vertex memory is not cleared.
module vertex_normal_accumulator import vna_pkg::*; #(
    parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    vna_chan_if.sink          cmd,
    vna_chan_if.source        rsp
);

    localparam int unsigned ADDR_W = $clog2(VERTEX_DEPTH);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(VERTEX_DEPTH - 1);

    function automatic logic in_range(input logic [INDEX_W-1:0] i);
        return {5'd0, i} < 17'(VERTEX_DEPTH);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [INDEX_W-1:0] i);
        logic [16:0] w;
        w = {5'd0, i};
        return w[ADDR_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] ia_reg, ib_reg, ic_reg;
    vertex_t           va_reg, vb_reg;
    logic              fwd_hit_reg;
    normal_t           fwd_data_reg;
    logic              zero_reg;
    logic              out_valid_reg;
    rsp_t              out_payload_reg;

    logic              vwr_en, vrd_en;
    logic [ADDR_W-1:0] vrd_addr;
    vertex_t           vwr_data, vrd_data;
    logic              nwr_en, nrd_en;
    logic [ADDR_W-1:0] nwr_addr, nrd_addr;
    normal_t           nwr_data, nrd_data, nram_q, acc_sum;
    cross_ctrl_t       cross_ctrl;
    cross_t            n;
    logic              load_va, load_vb, load_out, read_go, tri_go;
    logic              tri_ok;

    assign tri_ok = in_range(cmd.payload.index_a) && in_range(cmd.payload.index_b)
                    && in_range(cmd.payload.index_c);

    assign vwr_data.x = cmd.payload.coord_x;
    assign vwr_data.y = cmd.payload.coord_y;
    assign vwr_data.z = cmd.payload.coord_z;

    // A read in the same cycle as a write to that entry gets the written data forwarded.
    assign nram_q = fwd_hit_reg ? fwd_data_reg : nrd_data;

    assign acc_sum.x = sat_add(nram_q.x, n.x);
    assign acc_sum.y = sat_add(nram_q.y, n.y);
    assign acc_sum.z = sat_add(nram_q.z, n.z);

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        vwr_en     = 1'b0;
        vrd_en     = 1'b0;
        vrd_addr   = ia_reg;
        nwr_en     = 1'b0;
        nwr_addr   = ia_reg;
        nwr_data   = acc_sum;
        nrd_en     = 1'b0;
        nrd_addr   = ia_reg;
        cross_ctrl = '0;
        load_va    = 1'b0;
        load_vb    = 1'b0;
        load_out   = 1'b0;
        read_go    = 1'b0;
        tri_go     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                nwr_en   = 1'b1;
                nwr_addr = clr_cnt_reg;
                nwr_data = '0;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.payload.op)
                        OP_WRITE:
                        begin
                            vwr_en = in_range(cmd.payload.index_a);
                        end
                        OP_TRIANGLE:
                        begin
                            if (tri_ok)
                            begin
                                tri_go     = 1'b1;
                                vrd_en     = 1'b1;
                                vrd_addr   = to_addr(cmd.payload.index_a);
                                state_next = ST_VB;
                            end
                        end
                        OP_READ:
                        begin
                            read_go    = 1'b1;
                            nrd_en     = in_range(cmd.payload.index_a);
                            nrd_addr   = to_addr(cmd.payload.index_a);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_VB:
            begin
                load_va    = 1'b1;
                vrd_en     = 1'b1;
                vrd_addr   = ib_reg;
                state_next = ST_VC;
            end
            ST_VC:
            begin
                load_vb    = 1'b1;
                vrd_en     = 1'b1;
                vrd_addr   = ic_reg;
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                cross_ctrl.edge_en = 1'b1;
                state_next         = ST_MUL;
            end
            ST_MUL:
            begin
                cross_ctrl.prod_en = 1'b1;
                state_next         = ST_CROSS;
            end
            ST_CROSS:
            begin
                cross_ctrl.cross_en = 1'b1;
                nrd_en              = 1'b1;
                nrd_addr            = ia_reg;
                state_next          = ST_ACC_A;
            end
            ST_ACC_A:
            begin
                nwr_en     = 1'b1;
                nwr_addr   = ia_reg;
                nrd_en     = 1'b1;
                nrd_addr   = ib_reg;
                state_next = ST_ACC_B;
            end
            ST_ACC_B:
            begin
                nwr_en     = 1'b1;
                nwr_addr   = ib_reg;
                nrd_en     = 1'b1;
                nrd_addr   = ic_reg;
                state_next = ST_ACC_C;
            end
            ST_ACC_C:
            begin
                nwr_en     = 1'b1;
                nwr_addr   = ic_reg;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            fwd_hit_reg <= nrd_en && nwr_en && (nrd_addr == nwr_addr);
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= nwr_data;
        if (tri_go)
        begin
            ia_reg <= to_addr(cmd.payload.index_a);
            ib_reg <= to_addr(cmd.payload.index_b);
            ic_reg <= to_addr(cmd.payload.index_c);
        end
        if (read_go)
        begin
            zero_reg <= !in_range(cmd.payload.index_a);
        end
        if (load_va)
        begin
            va_reg <= vrd_data;
        end
        if (load_vb)
        begin
            vb_reg <= vrd_data;
        end
        if (load_out)
        begin
            out_payload_reg <= zero_reg ? '0 : rsp_t'(nram_q);
        end
    end

    vna_ram #(
        .WIDTH ($bits(vertex_t)),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (vwr_en),
        .wr_addr (to_addr(cmd.payload.index_a)),
        .wr_data (vwr_data),
        .rd_en   (vrd_en),
        .rd_addr (vrd_addr),
        .rd_data (vrd_data)
    );

    vna_ram #(
        .WIDTH ($bits(normal_t)),
        .DEPTH (VERTEX_DEPTH)
    ) u_normal_ram (
        .clk     (clk),
        .wr_en   (nwr_en),
        .wr_addr (nwr_addr),
        .wr_data (nwr_data),
        .rd_en   (nrd_en),
        .rd_addr (nrd_addr),
        .rd_data (nrd_data)
    );

    vna_cross u_cross (
        .clk  (clk),
        .ctrl (cross_ctrl),
        .va   (va_reg),
        .vb   (vb_reg),
        .vc   (vrd_data),
        .n    (n)
    );

`ifndef ASSERT_OFF
    a_fwd_only_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (state_reg == ST_ACC_B || state_reg == ST_ACC_C))
        else $error("forwarding hit outside the accumulate sequence");

    a_tri_reaches_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        tri_go |-> ##8 (state_reg == ST_ACC_C))
        else $error("triangle did not reach its last corner update in time");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_cnt_reg == CLR_LAST) |=> (state_reg == ST_IDLE))
        else $error("clear pass did not end after the last entry");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !nwr_en && !vwr_en)
        else $error("memory written while a normal read is pending");
`endif

endmodule

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vna_pkg::*;

    localparam int unsigned VDEPTH = VERTEX_DEPTH_DEF;
    localparam int unsigned POOL_N = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint NORMAL_HI = (longint'(1) <<< 47) - 1;
    localparam longint NORMAL_LO = -(longint'(1) <<< 47);
    localparam rsp_t NORMAL_ZERO = '0;

    typedef struct packed {
        cmd_t        c;
        logic [31:0] reps;
        logic        typed;
        rsp_t        want;
    } script_row_t;

    logic clk;
    logic rst_n;

    vna_chan_if #(.payload_t(cmd_t)) cmd_ch ();
    vna_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    vertex_normal_accumulator #(.VERTEX_DEPTH(VDEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Mesh state as the block should hold it.
    vertex_t     vtx [VDEPTH];
    bit          vtx_valid [VDEPTH];
    longint      sum_x [VDEPTH];
    longint      sum_y [VDEPTH];
    longint      sum_z [VDEPTH];

    rsp_t        pending_normals [$];
    script_row_t script [$];
    int unsigned pool [POOL_N];
    int          src_idle_pct;
    int          sink_idle_pct;
    int          fault_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic longint clip48(input longint s);
        if (s > NORMAL_HI)
        begin
            return NORMAL_HI;
        end
        if (s < NORMAL_LO)
        begin
            return NORMAL_LO;
        end
        return s;
    endfunction

    // Updates the mesh state for one command; returns 1 when a result word is due.
    function automatic bit apply_to_mesh(input cmd_t c, output rsp_t r);
        longint      e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        int unsigned a, b, d, k;
        int unsigned corner [3];
        r = '0;
        a = c.index_a;
        b = c.index_b;
        d = c.index_c;
        case (c.op)
            OP_WRITE:
            begin
                if (a < VDEPTH)
                begin
                    vtx[a].x = c.coord_x;
                    vtx[a].y = c.coord_y;
                    vtx[a].z = c.coord_z;
                    vtx_valid[a] = 1'b1;
                end
                return 1'b0;
            end
            OP_TRIANGLE:
            begin
                if (a >= VDEPTH || b >= VDEPTH || d >= VDEPTH)
                begin
                    return 1'b0;
                end
                e1x = longint'(vtx[b].x) - longint'(vtx[a].x);
                e1y = longint'(vtx[b].y) - longint'(vtx[a].y);
                e1z = longint'(vtx[b].z) - longint'(vtx[a].z);
                e2x = longint'(vtx[d].x) - longint'(vtx[b].x);
                e2y = longint'(vtx[d].y) - longint'(vtx[b].y);
                e2z = longint'(vtx[d].z) - longint'(vtx[b].z);
                nx = e1y * e2z - e1z * e2y;
                ny = e1z * e2x - e1x * e2z;
                nz = e1x * e2y - e1y * e2x;
                corner[0] = a;
                corner[1] = b;
                corner[2] = d;
                // Corners are updated one after another, so a repeated corner
                // saturates on each of its own updates.
                for (k = 0; k < 3; k++)
                begin
                    sum_x[corner[k]] = clip48(sum_x[corner[k]] + nx);
                    sum_y[corner[k]] = clip48(sum_y[corner[k]] + ny);
                    sum_z[corner[k]] = clip48(sum_z[corner[k]] + nz);
                end
                return 1'b0;
            end
            OP_READ:
            begin
                if (a < VDEPTH)
                begin
                    r.normal_x = ACC_W'(sum_x[a]);
                    r.normal_y = ACC_W'(sum_y[a]);
                    r.normal_z = ACC_W'(sum_z[a]);
                end
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic cmd_t mk_cmd(
        input logic [1:0]  op,
        input int unsigned a,
        input int unsigned b,
        input int unsigned d,
        input logic [15:0] x,
        input logic [15:0] y,
        input logic [15:0] z
    );
        cmd_t c;
        c.op = op;
        c.index_a = a[INDEX_W-1:0];
        c.index_b = b[INDEX_W-1:0];
        c.index_c = d[INDEX_W-1:0];
        c.coord_x = x;
        c.coord_y = y;
        c.coord_z = z;
        return c;
    endfunction

    task automatic plan_row(input cmd_t c, input int unsigned reps, input bit typed,
                            input rsp_t want);
        script_row_t row;
        row.c = c;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    function automatic logic [15:0] draw_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned written_pool_index();
        int unsigned k;
        do
        begin
            k = $urandom_range(0, POOL_N - 1);
        end
        while (!vtx_valid[pool[k]]);
        return pool[k];
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_cmd(input cmd_t w, input bit typed, input rsp_t want);
        rsp_t r;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= w;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        if (apply_to_mesh(w, r))
        begin
            pending_normals.push_back(typed ? want : r);
        end
        @(negedge clk);
    endtask

    task automatic wait_for_normals();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_normals.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin : check_normals
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.payload;
            if (pending_normals.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                begin
                    $display("unexpected result word: x=%0d y=%0d z=%0d",
                             got.normal_x, got.normal_y, got.normal_z);
                end
            end
            else
            begin
                want = pending_normals.pop_front();
                if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
                    got.normal_z !== want.normal_z)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("normal mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 want.normal_x, want.normal_y, want.normal_z,
                                 got.normal_x, got.normal_y, got.normal_z);
                    end
                end
            end
        end
    end

    initial
    begin
        cmd_t        w;
        script_row_t row;
        int unsigned i, n, phase, served, sel;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        src_idle_pct = 28;
        sink_idle_pct = 51;
        fault_count = 0;

        pool[0] = 0;
        pool[1] = 4095;
        pool[2] = 2048;
        pool[3] = 1;
        pool[4] = 2;
        for (i = 5; i < POOL_N; i++)
        begin
            pool[i] = $urandom_range(0, 4095);
        end

        // Normals read back as zero right after the clearing pass.
        plan_row(mk_cmd(OP_READ, 0, 4095, 4095, 16'h7fff, 16'h8000, 16'h7fff), 1, 1'b1,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 4095, 0, 0, 16'h8000, 16'h7fff, 16'h8000), 1, 1'b1,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_WRITE, 0, 4095, 0, 16'h8000, 16'h8000, 16'h8000), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_WRITE, 4095, 0, 4095, 16'h7fff, 16'h7fff, 16'h8000), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_WRITE, 2048, 2048, 2048, 16'h7fff, 16'h7fff, 16'h7fff), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_TRIANGLE, 0, 4095, 2048, 16'h0, 16'h0, 16'h0), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 2048, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        // Repeats of this near-maximal triangle build up large sums on all three corners.
        plan_row(mk_cmd(OP_TRIANGLE, 0, 4095, 2048, 16'h0, 16'h0, 16'h0), 30, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 0, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 4095, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 2048, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_TRIANGLE, 0, 2048, 4095, 16'h0, 16'h0, 16'h0), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 0, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_TRIANGLE, 0, 0, 4095, 16'h0, 16'h0, 16'h0), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_TRIANGLE, 2048, 4095, 2048, 16'h0, 16'h0, 16'h0), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 4095, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_UNUSED, 0, 4095, 0, 16'h7fff, 16'h8000, 16'h7fff), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_WRITE, 1, 0, 0, 16'h0064, 16'hff38, 16'h012c), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_WRITE, 2, 0, 0, 16'hfffb, 16'h0007, 16'hfff5), 1, 1'b0,
                 NORMAL_ZERO);
        plan_row(mk_cmd(OP_TRIANGLE, 1, 2, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 1, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 2, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 7, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b1, NORMAL_ZERO);
        plan_row(mk_cmd(OP_WRITE, 0, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_TRIANGLE, 0, 1, 2, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);
        plan_row(mk_cmd(OP_READ, 0, 0, 0, 16'h0, 16'h0, 16'h0), 1, 1'b0, NORMAL_ZERO);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            for (n = 0; n < row.reps; n++)
            begin
                push_cmd(row.c, row.typed, row.want);
            end
        end
        wait_for_normals();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 28;
                    sink_idle_pct = 51;
                end
                1:
                begin
                    src_idle_pct = 51;
                    sink_idle_pct = 28;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            served = 0;
            while (served < 125)
            begin
                sel = $urandom_range(0, 99);
                w.index_a = INDEX_W'($urandom_range(0, 4095));
                w.index_b = INDEX_W'($urandom_range(0, 4095));
                w.index_c = INDEX_W'($urandom_range(0, 4095));
                w.coord_x = draw_coord();
                w.coord_y = draw_coord();
                w.coord_z = draw_coord();
                if (sel < 30)
                begin
                    w.op = OP_WRITE;
                    if ($urandom_range(0, 99) < 85)
                    begin
                        w.index_a = INDEX_W'(pool[$urandom_range(0, POOL_N - 1)]);
                    end
                end
                else if (sel < 70)
                begin
                    // Triangles only ever touch vertices that hold a position.
                    w.op = OP_TRIANGLE;
                    w.index_a = INDEX_W'(written_pool_index());
                    w.index_b = INDEX_W'(written_pool_index());
                    w.index_c = INDEX_W'(written_pool_index());
                end
                else if (sel < 95)
                begin
                    w.op = OP_READ;
                    if ($urandom_range(0, 99) < 85)
                    begin
                        w.index_a = INDEX_W'(pool[$urandom_range(0, POOL_N - 1)]);
                    end
                end
                else
                begin
                    w.op = OP_UNUSED;
                end
                push_cmd(w, 1'b0, NORMAL_ZERO);
                if (w.op != OP_UNUSED)
                begin
                    served++;
                end
            end
            wait_for_normals();
        end

        // Let any stray result word show up before the final check.
        repeat (32) @(negedge clk);
        if (fault_count == 0 && pending_normals.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
